FILE: sv/swhc_pkg.sv
// ----------------------------------------------------------------------------
// swhc_pkg
// Shared types and constants of the sliding window hit counter.
// ----------------------------------------------------------------------------
package swhc_pkg;

  localparam int MAX_ENTRIES  = 512;
  localparam int PTR_W        = $clog2(MAX_ENTRIES);
  localparam int OCC_W        = $clog2(MAX_ENTRIES + 1);
  localparam int TIME_W       = 32;
  localparam int COUNT_W      = 32;
  localparam int WINDOW_W     = 10;
  localparam int TS_W         = 32;
  localparam int OUT_W        = 32;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(300);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_HIT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic rd_head;
    logic pop;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic expire;
    logic out_free;
  } dp_status_t;

endpackage

FILE: sv/swhc_ctrl.sv
// ----------------------------------------------------------------------------
// swhc_ctrl
// Sequencer: accept a transaction, expire old slots one per pass, commit.
// ----------------------------------------------------------------------------
module swhc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  swhc_pkg::dp_status_t status,
  output swhc_pkg::dp_cmd_t    cmd_o
);
  import swhc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = status.occ_zero ? ST_HIT : ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.expire ? ST_READ : ST_HIT;
      end
      ST_HIT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall       = 1'b0;
        cmd_o.load_item = in_valid;
      end
      ST_READ: begin
        cmd_o.rd_head = !status.occ_zero;
      end
      ST_CHECK: begin
        cmd_o.pop = status.expire;
      end
      ST_HIT: begin
        cmd_o.commit = status.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

FILE: sv/swhc_dp.sv
// ----------------------------------------------------------------------------
// swhc_dp
// Slot ring memory, pointers, running total and output register.
// ----------------------------------------------------------------------------
module swhc_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [swhc_pkg::WINDOW_W-1:0] cfg_wr_data,
  input  logic                         cmd,
  input  logic [swhc_pkg::TS_W-1:0]     timestamp,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [swhc_pkg::OUT_W-1:0]    window_count,
  input  swhc_pkg::dp_cmd_t             cmd_i,
  output swhc_pkg::dp_status_t          status
);
  import swhc_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [TIME_W-1:0]  slot_time [MAX_ENTRIES];
  logic [COUNT_W-1:0] slot_hits [MAX_ENTRIES];

  logic [WINDOW_W-1:0] window_len;
  logic [PTR_W-1:0]    head_ptr, tail_ptr;
  logic [OCC_W-1:0]    occupancy;
  logic [COUNT_W-1:0]  total_hits;
  logic [TIME_W-1:0]   now;
  logic                is_hit;
  logic [TIME_W-1:0]   newest_time;
  logic [COUNT_W-1:0]  newest_hits;
  logic [TIME_W-1:0]   rd_time;
  logic [COUNT_W-1:0]  rd_hits;

  logic [PTR_W-1:0]    newest_ptr, head_inc, tail_inc;
  logic [TIME_W-1:0]   age;
  logic                merge;
  logic                wr_en;
  logic [PTR_W-1:0]    wr_addr;
  logic [TIME_W-1:0]   wr_time;
  logic [COUNT_W-1:0]  wr_hits;
  logic [COUNT_W-1:0]  total_hit_next;
  logic [COUNT_W-1:0]  total_next;
  logic [63:0]         total_wide;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_ENTRIES - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
  endfunction

  assign newest_ptr = (tail_ptr == '0) ? PTR_W'(MAX_ENTRIES - 1) : tail_ptr - PTR_W'(1);
  assign head_inc   = ring_next(head_ptr);
  assign tail_inc   = ring_next(tail_ptr);
  assign age        = now - rd_time;

  assign status.occ_zero = (occupancy == '0);
  assign status.expire   = (occupancy != '0) && (now >= rd_time) &&
                           (64'(age) >= 64'(window_len));
  assign status.out_free = !out_valid || !out_stall;

  assign merge = (occupancy != '0) &&
                 ((now <= newest_time) || (occupancy == OCC_W'(MAX_ENTRIES)));

  always_comb begin
    wr_en   = cmd_i.commit && is_hit;
    wr_addr = merge ? newest_ptr : tail_ptr;
    wr_time = merge ? newest_time : now;
    wr_hits = merge ? sat_inc(newest_hits) : COUNT_W'(1);
  end

  assign total_hit_next = is_hit ? sat_inc(total_hits) : total_hits;
  assign total_next     = (total_hits >= rd_hits) ? total_hits - rd_hits : '0;
  assign total_wide     = 64'(total_hit_next);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_time[wr_addr] <= wr_time;
      slot_hits[wr_addr] <= wr_hits;
    end
    if (cmd_i.rd_head) begin
      rd_time <= slot_time[head_ptr];
      rd_hits <= slot_hits[head_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_item) begin
      now    <= TIME_W'(timestamp);
      is_hit <= cmd;
    end
    if (wr_en) begin
      newest_time <= wr_time;
      newest_hits <= wr_hits;
    end
    if (cmd_i.commit) begin
      window_count <= (total_wide > 64'hFFFF_FFFF) ? OUT_W'(32'hFFFF_FFFF)
                                                   : OUT_W'(total_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_RESET;
      head_ptr   <= '0;
      tail_ptr   <= '0;
      occupancy  <= '0;
      total_hits <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) window_len <= cfg_wr_data;
      if (cmd_i.pop) begin
        head_ptr   <= head_inc;
        occupancy  <= occupancy - OCC_W'(1);
        total_hits <= total_next;
      end else if (cmd_i.commit) begin
        total_hits <= total_hit_next;
        if (wr_en && !merge) begin
          tail_ptr  <= tail_inc;
          occupancy <= occupancy + OCC_W'(1);
        end
      end
      if (cmd_i.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/sliding_window_hit_counter.sv
// ----------------------------------------------------------------------------
// sliding_window_hit_counter
// Counts hits inside a sliding time window over a ring of timestamp slots.
// ----------------------------------------------------------------------------
// Sequence: a transaction is taken in ST_IDLE; each expired slot then costs
// a memory read (ST_READ) and a compare (ST_CHECK); ST_HIT commits the result.
// Throughput: the next transaction is taken once the last is committed, as
// the slot memory has one read port. The output register lets the result wait.
// Reset: synchronous; ring empty, total zero, window length 300. Slot memory
// contents are not cleared.
module sliding_window_hit_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [swhc_pkg::WINDOW_W-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [swhc_pkg::TS_W-1:0]     timestamp,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swhc_pkg::OUT_W-1:0]    window_count
);
  import swhc_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  swhc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd_o    (dp_cmd)
  );

  swhc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .timestamp    (timestamp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_count (window_count),
    .cmd_i        (dp_cmd),
    .status       (dp_status)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window hit counter. Hit and query
// transactions are queued by a stimulus block and fed through a bursty
// driver. A monitor under a varying stall pattern compares every result
// against a ring-based window count kept alongside the block. Directed
// corners cover the empty ring, same-time hits, earlier timestamps, a full
// ring, a zero window and the top of the timestamp range.
// ----------------------------------------------------------------------------
module tb_top;
  import swhc_pkg::*;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_HIT    = 1'b1;
  localparam int   IDLE_LIMIT = 8000;
  localparam int   SETTLE     = 12;

  typedef struct {
    logic            cmd;
    logic [TS_W-1:0] ts;
  } hit_req_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [WINDOW_W-1:0] cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                cmd = CMD_QUERY;
  logic [TS_W-1:0]     timestamp = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OUT_W-1:0]    window_count;

  hit_req_t         pending_req_q[$];
  logic [OUT_W-1:0] expected_count_q[$];
  int               err_cnt = 0;
  int               results_seen = 0;

  // window state tracked alongside the block
  logic [TIME_W-1:0]   rec_time[MAX_ENTRIES];
  logic [COUNT_W-1:0]  rec_hits[MAX_ENTRIES];
  int                  oldest_idx = 0;
  int                  next_idx = 0;
  int                  used_cnt = 0;
  logic [COUNT_W-1:0]  hits_in_window = '0;
  logic [WINDOW_W-1:0] win_len = WINDOW_RESET;

  sliding_window_hit_counter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .timestamp    (timestamp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_count (window_count)
  );

  always #1 clk = ~clk;

  function automatic logic [COUNT_W-1:0] sat_plus_one(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [OUT_W-1:0] count_after_hit(input logic hit,
                                                       input logic [TS_W-1:0] ts);
    logic [TIME_W-1:0] now;
    int                last;
    now = TIME_W'(ts);
    // drop entries that have left the window
    while (used_cnt > 0 && now >= rec_time[oldest_idx] &&
           (now - rec_time[oldest_idx]) >= TIME_W'(win_len)) begin
      hits_in_window = (hits_in_window >= rec_hits[oldest_idx]) ?
                       hits_in_window - rec_hits[oldest_idx] : '0;
      oldest_idx = (oldest_idx == MAX_ENTRIES - 1) ? 0 : oldest_idx + 1;
      used_cnt--;
    end
    if (hit == CMD_HIT) begin
      last = (next_idx == 0) ? MAX_ENTRIES - 1 : next_idx - 1;
      if (used_cnt > 0 && (now <= rec_time[last] || used_cnt >= MAX_ENTRIES)) begin
        rec_hits[last] = sat_plus_one(rec_hits[last]);
      end else begin
        rec_time[next_idx] = now;
        rec_hits[next_idx] = COUNT_W'(1);
        next_idx = (next_idx == MAX_ENTRIES - 1) ? 0 : next_idx + 1;
        used_cnt++;
      end
      hits_in_window = sat_plus_one(hits_in_window);
    end
    if (COUNT_W > OUT_W && hits_in_window > {OUT_W{1'b1}})
      return '1;
    return OUT_W'(hits_in_window);
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // driver: bursts of transactions with random gaps
  int       burst_left = 0;
  int       gap_left = 0;
  hit_req_t drv_req;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_count_q.insert(expected_count_q.size(), count_after_hit(cmd, timestamp));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_req_q.size() > 0) begin
          drv_req = pending_req_q[0];
          pending_req_q.delete(0);
          in_valid <= 1'b1;
          cmd <= drv_req.cmd;
          timestamp <= drv_req.ts;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern whose mode is redrawn at random, plus one long hold
  int  rx_cycle = 0;
  int  rx_mode = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0)
      rx_mode = $urandom_range(0, 3);
    if (!hold_done && results_seen >= 150) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        1: out_stall <= ($urandom_range(0, 1) == 1);
        2: out_stall <= (rx_cycle % 3 == 0);
        3: out_stall <= ($urandom_range(0, 7) != 0);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // monitor
  logic [OUT_W-1:0] want_count;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_count_q.size() == 0) begin
        report_mismatch("unexpected result window_count", window_count, '0);
      end else begin
        want_count = expected_count_q[0];
        expected_count_q.delete(0);
        if (window_count !== want_count)
          report_mismatch("window_count", window_count, want_count);
      end
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sliding_window_hit_counter: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  logic [TS_W-1:0] cur_ts = '0;

  task automatic push_req(input logic c, input logic [TS_W-1:0] ts);
    hit_req_t r;
    r.cmd = c;
    r.ts = ts;
    pending_req_q.insert(pending_req_q.size(), r);
  endtask

  task automatic drain();
    do
      @(negedge clk);
    while (pending_req_q.size() != 0 || in_valid || expected_count_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [WINDOW_W-1:0] len);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_len = len;
  endtask

  task automatic random_run(input int n);
    int               r;
    int               w;
    logic [TS_W-1:0]  back;
    logic             c;
    w = int'(win_len);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      c = ($urandom_range(0, 9) < 7) ? CMD_HIT : CMD_QUERY;
      if (r < 10) begin
        push_req(c, cur_ts);
      end else if (r < 70) begin
        cur_ts = cur_ts + $urandom_range(1, w / 8 + 1);
        push_req(c, cur_ts);
      end else if (r < 85) begin
        cur_ts = cur_ts + $urandom_range(w / 2, w * 2 + 2);
        push_req(c, cur_ts);
      end else if (r < 92) begin
        cur_ts = cur_ts + $urandom_range(0, 1 << 20);
        push_req(c, cur_ts);
      end else if (r < 97) begin
        back = $urandom_range(1, 64);
        push_req(c, (cur_ts > back) ? cur_ts - back : '0);
      end else begin
        cur_ts = cur_ts + 1;
        push_req(c, cur_ts);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset window: empty ring, same-time hits, earlier time, edge of window
    push_req(CMD_QUERY, 0);
    push_req(CMD_HIT, 0);
    push_req(CMD_HIT, 0);
    push_req(CMD_HIT, 5);
    push_req(CMD_QUERY, 299);
    push_req(CMD_QUERY, 300);
    push_req(CMD_HIT, 2);
    push_req(CMD_HIT, 305);
    push_req(CMD_QUERY, 305);

    // zero window
    write_window(WINDOW_W'(0));
    push_req(CMD_HIT, 400);
    push_req(CMD_HIT, 400);
    push_req(CMD_QUERY, 400);
    push_req(CMD_HIT, 401);
    cur_ts = 1000;

    // fill the ring past its capacity, then expire it all at once
    write_window('1);
    for (int i = 0; i < MAX_ENTRIES + 8; i++) begin
      cur_ts = cur_ts + 1;
      push_req(CMD_HIT, cur_ts);
    end
    push_req(CMD_QUERY, cur_ts);
    cur_ts = cur_ts + 2000;
    push_req(CMD_QUERY, cur_ts);

    write_window(WINDOW_W'(1));
    random_run(80);
    write_window(WINDOW_W'(512));
    random_run(90);
    write_window(WINDOW_W'(0));
    random_run(50);
    write_window(WINDOW_W'($urandom_range(2, 1023)));
    random_run(70);
    write_window(WINDOW_W'($urandom_range(2, 1023)));
    random_run(70);
    write_window(WINDOW_W'(300));
    random_run(50);
    drain();
    random_run(50);

    // top of the timestamp range
    write_window('1);
    push_req(CMD_HIT, 32'hFFFF_FC00);
    push_req(CMD_HIT, 32'hFFFF_FFFF);
    push_req(CMD_HIT, 32'hFFFF_FFFF);
    push_req(CMD_QUERY, 32'hFFFF_FFFF);
    write_window(WINDOW_W'(1));
    push_req(CMD_QUERY, 32'hFFFF_FFFF);
    push_req(CMD_HIT, 0);
    push_req(CMD_QUERY, 32'hFFFF_FFFF);

    drain();
    if (err_cnt == 0) begin
      $display("sliding_window_hit_counter: match");
    end else begin
      $display("sliding_window_hit_counter: mismatch");
    end
    $finish;
  end

endmodule
